// ===== rtl/sebp_pkg.sv =====
// Shared types and constants of the serial EEPROM bit protocol unit.
package sebp_pkg;

	// One input word: a single bus access.
	typedef struct packed {
		logic       req_type;
		logic       bit_in;
		logic [6:0] transfer_length;
	} req_t;

	// One result word.
	typedef struct packed {
		logic       read_bit;
		logic [1:0] phase;
		logic       store_dirty;
	} rsp_t;

	// Access kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Protocol phases, also reported on the result.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RECV = 2'd1;
	localparam logic [1:0] PH_READ = 2'd2;

	// Command codes, first received bit in the upper position.
	localparam logic [1:0] CMD_READ  = 2'b11;
	localparam logic [1:0] CMD_WRITE = 2'b10;

	localparam int unsigned BLOCK_BITS   = 64;
	localparam int unsigned MAX_CMD_BITS = 128;

	localparam logic [6:0] READ_QUEUE_LEN  = 7'd68;
	localparam logic [6:0] READ_LEAD_ZEROS = 7'd4;
	localparam logic [6:0] ADDR_LEN_OFFSET = 7'd3;
	localparam logic [6:0] CMD_HEADER_BITS = 7'd2;
	localparam logic [6:0] ADDR_W_LIMIT    = 7'd15;

endpackage

// ===== rtl/sebp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module sebp_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sebp_seq.sv =====
// Bit sequencer: command collection, address assembly and block store access.
module sebp_seq #(
	parameter int unsigned BLOCK_COUNT = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  sebp_pkg::req_t item,
	output sebp_pkg::rsp_t res
);

	import sebp_pkg::*;

	localparam int unsigned AW = $clog2(BLOCK_COUNT);

	// Entry i holds two to the power i, reduced modulo the block count.
	function automatic logic [15*AW-1:0] weight_table();
		logic [15*AW-1:0] t;
		int               v;
		t = '0;
		v = 1 % BLOCK_COUNT;
		for (int i = 0; i < 15; i++) begin
			t[i*AW +: AW] = AW'(v);
			v = (v * 2) % BLOCK_COUNT;
		end
		return t;
	endfunction

	localparam logic [15*AW-1:0] WEIGHTS = weight_table();

	// Control state.
	logic [1:0]  phase_q, phase_nxt;
	logic [6:0]  pos_q, pos_nxt;
	logic [6:0]  cmd_len_q, cmd_len_nxt;
	logic [3:0]  addr_w_q, addr_w_nxt;
	logic        width_known_q, width_known_nxt;
	logic        dirty_q, dirty_nxt;
	logic        rd_load_q, rd_load_nxt;

	// Payload state.
	logic [1:0]            hdr_q, hdr_nxt;
	logic [AW-1:0]         addr_q, addr_nxt;
	logic [BLOCK_BITS:0]   wr_shift_q, wr_shift_nxt;
	logic [BLOCK_BITS-1:0] rd_shift_q;

	logic        is_wr, is_rd, start, recv, rd_active, done;
	logic [6:0]  pos_cur, len_cur, pos_inc, len_off, a_idx_full;
	logic [3:0]  aw_cur, aw_from_len;
	logic [1:0]  hdr_base;
	logic [AW-1:0]       addr_base, weight;
	logic [AW:0]         addr_sum;
	logic [BLOCK_BITS:0] wsh_base;
	logic        keep, bit_k, a_hit, rbit, rd_shift_en;

	logic                  mem_we, mem_re;
	logic [BLOCK_BITS-1:0] mem_rdata;

	always_comb begin
		is_wr     = step && (item.req_type == REQ_WRITE);
		is_rd     = step && (item.req_type == REQ_READ);
		start     = is_wr && (phase_q == PH_IDLE);
		recv      = is_wr && ((phase_q == PH_IDLE) || (phase_q == PH_RECV));
		rd_active = is_rd && (phase_q == PH_READ);

		len_off = item.transfer_length - ADDR_LEN_OFFSET;
		if (item.transfer_length < ADDR_LEN_OFFSET) begin
			aw_from_len = 4'd0;
		end else if (len_off > ADDR_W_LIMIT) begin
			aw_from_len = ADDR_W_LIMIT[3:0];
		end else begin
			aw_from_len = len_off[3:0];
		end

		// A new command starts from a cleared buffer.
		pos_cur   = start ? 7'd0 : pos_q;
		len_cur   = start ? item.transfer_length : cmd_len_q;
		aw_cur    = (start && !width_known_q) ? aw_from_len : addr_w_q;
		hdr_base  = start ? 2'b00 : hdr_q;
		addr_base = start ? '0 : addr_q;
		wsh_base  = start ? '0 : wr_shift_q;

		keep  = {1'b0, pos_cur} < 8'(MAX_CMD_BITS);
		bit_k = item.bit_in && keep;

		hdr_nxt = hdr_base;
		if (pos_cur == 7'd0) begin
			hdr_nxt[1] = bit_k;
		end
		if (pos_cur == 7'd1) begin
			hdr_nxt[0] = bit_k;
		end

		// The address is summed modulo the block count as its bits arrive.
		a_idx_full = pos_cur - CMD_HEADER_BITS;
		a_hit      = (pos_cur >= CMD_HEADER_BITS) && (a_idx_full < {3'b000, aw_cur});
		weight     = WEIGHTS[a_idx_full[3:0]*AW +: AW];
		addr_sum   = {1'b0, addr_base} + ((bit_k && a_hit) ? {1'b0, weight} : '0);
		if (addr_sum >= (AW+1)'(BLOCK_COUNT)) begin
			addr_sum = addr_sum - (AW+1)'(BLOCK_COUNT);
		end

		wr_shift_nxt = {wsh_base[BLOCK_BITS-1:0], bit_k};
		pos_inc      = pos_cur + 7'd1;
		done         = recv && (pos_inc >= len_cur);

		rbit        = (pos_q < READ_LEAD_ZEROS) ? 1'b0 : rd_shift_q[BLOCK_BITS-1];
		rd_shift_en = rd_active && (pos_q >= READ_LEAD_ZEROS);

		phase_nxt       = phase_q;
		pos_nxt         = pos_q;
		cmd_len_nxt     = cmd_len_q;
		addr_w_nxt      = addr_w_q;
		width_known_nxt = width_known_q;
		dirty_nxt       = dirty_q;
		addr_nxt        = addr_q;
		rd_load_nxt     = 1'b0;
		mem_we          = 1'b0;
		mem_re          = 1'b0;

		if (start) begin
			cmd_len_nxt     = item.transfer_length;
			addr_w_nxt      = aw_cur;
			width_known_nxt = 1'b1;
		end

		if (recv) begin
			phase_nxt = PH_RECV;
			pos_nxt   = pos_inc;
			addr_nxt  = addr_sum[AW-1:0];
			if (done) begin
				if (hdr_nxt == CMD_READ) begin
					mem_re      = 1'b1;
					rd_load_nxt = 1'b1;
					pos_nxt     = 7'd0;
					cmd_len_nxt = READ_QUEUE_LEN;
					phase_nxt   = PH_READ;
				end else if (hdr_nxt == CMD_WRITE) begin
					mem_we    = 1'b1;
					dirty_nxt = 1'b1;
					phase_nxt = PH_IDLE;
				end else begin
					phase_nxt = PH_IDLE;
				end
			end
		end

		if (rd_active) begin
			pos_nxt = pos_q + 7'd1;
			if (pos_nxt >= READ_QUEUE_LEN) begin
				phase_nxt = PH_IDLE;
			end
		end

		res.read_bit    = rd_active ? rbit : 1'b1;
		res.phase       = phase_nxt;
		res.store_dirty = dirty_nxt;
	end

	sebp_ram #(
		.WIDTH(BLOCK_BITS),
		.DEPTH(BLOCK_COUNT)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_nxt),
		.wdata(wr_shift_nxt[BLOCK_BITS:1]),
		.re   (mem_re),
		.raddr(addr_nxt),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			pos_q         <= 7'd0;
			cmd_len_q     <= 7'd0;
			addr_w_q      <= 4'd0;
			width_known_q <= 1'b0;
			dirty_q       <= 1'b0;
			rd_load_q     <= 1'b0;
		end else begin
			phase_q       <= phase_nxt;
			pos_q         <= pos_nxt;
			cmd_len_q     <= cmd_len_nxt;
			addr_w_q      <= addr_w_nxt;
			width_known_q <= width_known_nxt;
			dirty_q       <= dirty_nxt;
			rd_load_q     <= rd_load_nxt;
		end
	end

	// The block reaches the read shift register while the leading zeros go out.
	always_ff @(posedge clk) begin
		if (recv) begin
			hdr_q      <= hdr_nxt;
			addr_q     <= addr_sum[AW-1:0];
			wr_shift_q <= wr_shift_nxt;
		end
		if (rd_load_q) begin
			rd_shift_q <= mem_rdata;
		end else if (rd_shift_en) begin
			rd_shift_q <= {rd_shift_q[BLOCK_BITS-2:0], 1'b0};
		end
	end

`ifndef ASSERT_OFF
	a_load_at_queue_head: assert property (@(posedge clk) disable iff (!arst_n)
		rd_load_q |-> (phase_q == PH_READ) && (pos_q == 7'd0))
		else $error("block load outside the head of a read queue");

	a_read_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_READ) |-> (pos_q < READ_QUEUE_LEN))
		else $error("read position beyond the queue");

	a_one_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in one cycle");

	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dirty_q |=> dirty_q)
		else $error("dirty flag cleared");
`endif

endmodule

// ===== rtl/serial_eeprom_bit_protocol_unit.sv =====
// Top level of the serial EEPROM bit protocol unit: handshake and result register.
//
// The unit takes one bus access word per clock and returns one result word for each, in the
// cycle after acceptance, from an output register; a new word is accepted while that
// register still waits to be taken, and the input stalls only when the register is full and
// the result side stalls. The block store is a single memory with one write and one read
// port; a write command stores its block in the cycle of its last bit, and a read command
// issues its read in that cycle, the data ready in the next cycle while the four leading
// zero bits are still being returned, so no access ever waits on the memory. The store has
// no clearing pass after reset; a block that was never written reads back undefined.
module serial_eeprom_bit_protocol_unit #(
	parameter int unsigned BLOCK_COUNT = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sebp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sebp_pkg::rsp_t rsp
);

	import sebp_pkg::*;

	logic accept;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t step_res;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	sebp_seq #(
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (accept),
		.item  (req),
		.res   (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= step_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted word produced no result");
`endif

endmodule

// ===== tb/sv/serial_eeprom_bit_protocol_unit_tb.sv =====
// Self-checking testbench for the serial EEPROM bit protocol unit.
module serial_eeprom_bit_protocol_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sebp_pkg::*;

	localparam int BLOCK_COUNT = 1024;
	// The first command has length 7, which fixes four address bits for the whole run.
	localparam int ADDR_W      = 4;
	localparam int WORD_TARGET = 1800;
	// The cycle limit leaves a wide margin for the run.
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 31;
	localparam int DIR_ROWS    = 24;

	localparam logic PINNED    = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct {
		logic [1:0]   phase;
		logic [127:0] bits;
		logic [6:0]   pos;
		logic [6:0]   cmd_len;
		logic [3:0]   addr_w;
		logic         addr_w_set;
		logic         dirty;
	} eeprom_state_t;

	typedef struct packed {
		req_t w;
		logic pinned;
		rsp_t want;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic pin_on  = 1'b0;
	rsp_t pin_rsp = '0;
	logic calm;

	eeprom_state_t ee;
	logic [63:0]   block_mem [BLOCK_COUNT];
	rsp_t          pending_rsp [$];
	rsp_t          next_rsp;
	rsp_t          oldest_rsp;
	dir_row_t      directed [DIR_ROWS];

	int errors          = 0;
	int words_done      = 0;
	int words_ignored   = 0;
	int results_checked = 0;
	int reads_issued    = 0;
	int writes_issued   = 0;
	int cycles          = 0;

	assign calm = words_done >= 700 && words_done < 1000;

	serial_eeprom_bit_protocol_unit #(.BLOCK_COUNT(BLOCK_COUNT)) dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// Applies one bus access to the mirrored protocol state and returns its result.
	function automatic rsp_t eeprom_access(input req_t w);
		rsp_t        r;
		logic [1:0]  kind;
		logic [15:0] raw_addr;
		int          addr;
		int          src;
		logic [63:0] blk;
		r.read_bit = 1'b1;
		if (w.req_type == REQ_WRITE) begin
			if (ee.phase == PH_IDLE) begin
				ee.phase   = PH_RECV;
				ee.bits    = '0;
				ee.pos     = '0;
				ee.cmd_len = w.transfer_length;
				// Only the very first command decides how many address bits follow the header.
				if (!ee.addr_w_set) begin
					ee.addr_w_set = 1'b1;
					if (w.transfer_length < ADDR_LEN_OFFSET)
						ee.addr_w = '0;
					else if (w.transfer_length - ADDR_LEN_OFFSET > ADDR_W_LIMIT)
						ee.addr_w = 4'd15;
					else
						ee.addr_w = 4'(w.transfer_length - ADDR_LEN_OFFSET);
				end
			end
			if (ee.phase == PH_RECV) begin
				ee.bits[ee.pos] = w.bit_in;
				ee.pos = ee.pos + 7'd1;
				if (ee.pos >= ee.cmd_len) begin
					kind = {ee.bits[0], ee.bits[1]};
					raw_addr = '0;
					for (int i = 0; i < ee.addr_w; i++)
						raw_addr[i] = ee.bits[CMD_HEADER_BITS + i];
					addr = int'(raw_addr) % BLOCK_COUNT;
					ee.phase = PH_IDLE;
					if (kind == CMD_READ) begin
						blk = block_mem[addr];
						ee.bits = '0;
						for (int i = 0; i < BLOCK_BITS; i++)
							ee.bits[READ_LEAD_ZEROS + i] = blk[BLOCK_BITS - 1 - i];
						ee.pos     = '0;
						ee.cmd_len = READ_QUEUE_LEN;
						ee.phase   = PH_READ;
						reads_issued++;
					end else if (kind == CMD_WRITE) begin
						// The block is taken backwards from two places short of the final
						// position; positions before the start of the buffer give zeros.
						src = int'(ee.pos) - int'(CMD_HEADER_BITS);
						for (int i = 0; i < BLOCK_BITS; i++) begin
							blk[i] = (src >= 0) ? ee.bits[src] : 1'b0;
							src--;
						end
						block_mem[addr] = blk;
						ee.dirty = 1'b1;
						writes_issued++;
					end
				end
			end
		end else if (ee.phase == PH_READ) begin
			r.read_bit = ee.bits[ee.pos];
			ee.pos = ee.pos + 7'd1;
			if (ee.pos >= ee.cmd_len)
				ee.phase = PH_IDLE;
		end
		r.phase       = ee.phase;
		r.store_dirty = ee.dirty;
		return r;
	endfunction

	function automatic req_t any_word(input logic kind);
		req_t w;
		w.req_type        = kind;
		w.bit_in          = 1'($urandom);
		w.transfer_length = 7'($urandom);
		return w;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** serial_eeprom_bit_protocol_unit: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				if ((req.req_type == REQ_READ) != (ee.phase == PH_READ))
					words_ignored++;
				else
					words_done++;
				next_rsp = eeprom_access(req);
				pending_rsp.push_back(pin_on ? pin_rsp : next_rsp);
			end
			if (rsp_valid && !rsp_stall) begin
				results_checked++;
				if (pending_rsp.size() == 0) begin
					flag_mismatch($sformatf("result word %b arrived with nothing expected", rsp));
				end else begin
					oldest_rsp = pending_rsp.pop_front();
					if (rsp.read_bit !== oldest_rsp.read_bit)
						flag_mismatch($sformatf("read_bit %b, expected %b",
							rsp.read_bit, oldest_rsp.read_bit));
					if (rsp.phase !== oldest_rsp.phase)
						flag_mismatch($sformatf("phase %0d, expected %0d",
							rsp.phase, oldest_rsp.phase));
					if (rsp.store_dirty !== oldest_rsp.store_dirty)
						flag_mismatch($sformatf("store_dirty %b, expected %b",
							rsp.store_dirty, oldest_rsp.store_dirty));
				end
			end
		end
	end

	always @(negedge clk) begin
		rsp_stall <= !calm && $urandom_range(0, 99) < IDLE_PCT;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input req_t w, input logic pinned, input rsp_t want);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		pin_on    <= pinned;
		pin_rsp   <= want;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic hold_off();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending_rsp.size() != 0);
	endtask

	// Sends one command bit by bit; bits after the header and address are random.
	task automatic run_command(input logic [1:0] code, input int unsigned addr,
			input int unsigned len);
		logic [127:0] bits;
		int unsigned  n;
		req_t         w;
		bits = {$urandom, $urandom, $urandom, $urandom};
		bits[0] = code[1];
		bits[1] = code[0];
		for (int i = 0; i < ADDR_W; i++)
			bits[CMD_HEADER_BITS + i] = addr[i];
		n = (len == 0) ? 1 : len;
		for (int i = 0; i < n; i++) begin
			// A read between command bits is answered with a one and leaves the command alone.
			if (i > 0 && $urandom_range(0, 99) < 8)
				send_word(any_word(REQ_READ), PREDICTED, '0);
			w = any_word(REQ_WRITE);
			w.bit_in = bits[i];
			if (i == 0)
				w.transfer_length = 7'(len);
			send_word(w, PREDICTED, '0);
		end
	endtask

	// Brings the unit back to idle: drains pending read data or completes a stray command.
	task automatic settle();
		while (ee.phase != PH_IDLE) begin
			if (ee.phase == PH_READ)
				send_word(any_word($urandom_range(0, 99) < 8 ? REQ_WRITE : REQ_READ),
					PREDICTED, '0);
			else
				send_word(any_word($urandom_range(0, 99) < 8 ? REQ_READ : REQ_WRITE),
					PREDICTED, '0);
		end
	endtask

	initial begin
		int unsigned pick;
		ee = '{PH_IDLE, '0, '0, '0, '0, 1'b0, 1'b0};
		directed = '{
			// Reads while idle.
			'{'{REQ_READ,  1'b0, 7'd0},   PINNED,    '{1'b1, PH_IDLE, 1'b0}},
			'{'{REQ_READ,  1'b1, 7'd127}, PINNED,    '{1'b1, PH_IDLE, 1'b0}},
			// First command: a short write to block 5, length 7.
			'{'{REQ_WRITE, 1'b1, 7'd7},   PINNED,    '{1'b1, PH_RECV, 1'b0}},
			'{'{REQ_READ,  1'b0, 7'd0},   PINNED,    '{1'b1, PH_RECV, 1'b0}},
			'{'{REQ_WRITE, 1'b0, 7'd127}, PREDICTED, '0},
			'{'{REQ_WRITE, 1'b1, 7'd0},   PREDICTED, '0},
			'{'{REQ_WRITE, 1'b0, 7'd85},  PREDICTED, '0},
			'{'{REQ_WRITE, 1'b1, 7'd42},  PREDICTED, '0},
			'{'{REQ_WRITE, 1'b0, 7'd127}, PREDICTED, '0},
			'{'{REQ_WRITE, 1'b1, 7'd127}, PINNED,    '{1'b1, PH_IDLE, 1'b1}},
			// Zero length: unknown code, then a write of an empty block to block 0.
			'{'{REQ_WRITE, 1'b0, 7'd0},   PINNED,    '{1'b1, PH_IDLE, 1'b1}},
			'{'{REQ_WRITE, 1'b1, 7'd0},   PINNED,    '{1'b1, PH_IDLE, 1'b1}},
			// Unknown code 01 over three bits.
			'{'{REQ_WRITE, 1'b0, 7'd3},   PINNED,    '{1'b1, PH_RECV, 1'b1}},
			'{'{REQ_WRITE, 1'b1, 7'd3},   PINNED,    '{1'b1, PH_RECV, 1'b1}},
			'{'{REQ_WRITE, 1'b1, 7'd3},   PINNED,    '{1'b1, PH_IDLE, 1'b1}},
			// Read of block 5.
			'{'{REQ_WRITE, 1'b1, 7'd6},   PINNED,    '{1'b1, PH_RECV, 1'b1}},
			'{'{REQ_WRITE, 1'b1, 7'd6},   PREDICTED, '0},
			'{'{REQ_WRITE, 1'b1, 7'd6},   PREDICTED, '0},
			'{'{REQ_WRITE, 1'b0, 7'd6},   PREDICTED, '0},
			'{'{REQ_WRITE, 1'b1, 7'd6},   PREDICTED, '0},
			'{'{REQ_WRITE, 1'b0, 7'd6},   PINNED,    '{1'b1, PH_READ, 1'b1}},
			'{'{REQ_READ,  1'b1, 7'd0},   PINNED,    '{1'b0, PH_READ, 1'b1}},
			// A write while read data is pending is ignored.
			'{'{REQ_WRITE, 1'b1, 7'd127}, PINNED,    '{1'b1, PH_READ, 1'b1}},
			'{'{REQ_READ,  1'b0, 7'd127}, PREDICTED, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < DIR_ROWS; k++)
			send_word(directed[k].w, directed[k].pinned, directed[k].want);
		settle();

		// Every reachable block gets data here, so no later read finds one unwritten.
		for (int a = 0; a < (1 << ADDR_W); a++)
			run_command(CMD_WRITE, a, CMD_HEADER_BITS + ADDR_W + $urandom_range(0, BLOCK_BITS));
		hold_off();

		while (words_done < WORD_TARGET) begin
			if (ee.phase != PH_IDLE) begin
				settle();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					run_command(CMD_WRITE, $urandom_range(0, 15),
						$urandom_range(0, 99) < 55 ? CMD_HEADER_BITS + ADDR_W + BLOCK_BITS
							: $urandom_range(0, 127));
				else if (pick < 80)
					run_command(CMD_READ, $urandom_range(0, 15),
						$urandom_range(0, 99) < 70 ? CMD_HEADER_BITS + ADDR_W
							: $urandom_range(0, 127));
				else
					send_word(any_word(1'($urandom)), PREDICTED, '0);
			end
		end
		hold_off();
		repeat (8) @(negedge clk);

		$display("Covered %0d effective and %0d ignored words, %0d read and %0d write commands.",
			words_done, words_ignored, reads_issued, writes_issued);
		$display("Checked %0d result words, %0d mismatches.", results_checked, errors);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("** serial_eeprom_bit_protocol_unit: PASSED **");
		else
			$display("** serial_eeprom_bit_protocol_unit: FAILED **");
		$finish;
	end

endmodule

// ===== serial_eeprom_bit_protocol_unit.f =====
rtl/sebp_pkg.sv
rtl/sebp_ram.sv
rtl/sebp_seq.sv
rtl/serial_eeprom_bit_protocol_unit.sv
tb/sv/serial_eeprom_bit_protocol_unit_tb.sv
